// File: hdl/sau_pkg.sv
// Shared types and constants for the stack arithmetic unit.
// Used by sau_div and stack_arith_unit; depends on nothing.
`default_nettype none
package sau_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 7;

  typedef enum logic [2:0] {
    FN_PUSH = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_DIV  = 3'd3,
    FN_MUL  = 3'd4,
    FN_MOD  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

// File: hdl/sau_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sau_pkg for the data width and the result struct.
`default_nettype none
module sau_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sau_pkg::DATA_W-1:0] dividend,
  input  wire logic [sau_pkg::DATA_W-1:0] divisor,
  output sau_pkg::div_res_t               res
);
  import sau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              fin_r, fin_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = '0;
      quo_nxt   = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      dvs_nxt   = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      neg_q_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r_nxt = dividend[DATA_W-1];
    end else if (busy_r) begin
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r   <= cnt_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign res.done = fin_r;
  assign res.quot = neg_q_r ? (~quo_r + DATA_W'(1)) : quo_r;
  assign res.rem  = neg_r_r ? (~rem_r + DATA_W'(1)) : rem_r;

endmodule
`default_nettype wire

// File: hdl/stack_arith_unit.sv
// Bounded integer stack with add, sub, mul, div and mod on its two top entries.
// Push, unused codes and a too-short stack go straight to S_DONE, division by zero via
// S_OPND, add/sub/mul via S_OPND and S_WB, div/mod via S_OPND, S_DIV (sau_div) and S_WB.
// One item at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset empties the stack; stack memory contents are not cleared.
// Depends on sau_pkg and sau_div.
`default_nettype none
module stack_arith_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [2:0]  in_tuser,   // func[2:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // top_value[31:0], stack_depth[38:32], zero pad
  output      logic [1:0]  out_tuser   // status[1:0]
);
  import sau_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_OPND = 6'b000010,
    S_DIV  = 6'b000100,
    S_WB   = 6'b001000,
    S_DONE = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  func_t             func_r, func_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [CW-1:0]     cnt_m2;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              div_start;
  div_res_t          div_res;
  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;
  logic              out_free;

  sau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (top_r),
    .res      (div_res)
  );

  assign cnt_m2    = count_r - CW'(2);
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    res_nxt    = res_r;
    func_nxt   = func_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = cnt_m2[AW-1:0];
    mem_wdata  = res_r;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = func_t'(in_tuser);
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_tuser)
            FN_PUSH: begin
              if (count_r == CW'(STACK_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_tdata;
                top_nxt   = in_tdata;
                count_nxt = count_r + CW'(1);
              end
            end
            FN_ADD, FN_SUB, FN_DIV, FN_MUL, FN_MOD: begin
              if (count_r < CW'(2)) begin
                status_nxt = ST_SHORT;
              end else begin
                state_nxt = S_OPND;
              end
            end
            default: ;
          endcase
        end
      end
      S_OPND: begin
        state_nxt = S_WB;
        case (func_r)
          FN_ADD:  res_nxt = rd_data_r + top_r;
          FN_SUB:  res_nxt = rd_data_r - top_r;
          FN_MUL:  res_nxt = rd_data_r * top_r;
          default: begin
            if (top_r == '0) begin
              status_nxt = ST_DIVZERO;
              state_nxt  = S_DONE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_res.done) begin
          res_nxt   = (func_r == FN_DIV) ? div_res.quot : div_res.rem;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        top_nxt   = res_r;
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = out_free ? S_IDLE : S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= stack_mem[cnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if ((state_r == S_DONE || state_r == S_WAIT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    top_r    <= top_nxt;
    res_r    <= res_nxt;
    func_r   <= func_nxt;
    status_r <= status_nxt;
    if ((state_r == S_DONE || state_r == S_WAIT) && out_free) begin
      out_tuser_r <= status_r;
      out_tdata_r <= {1'b0, DEPTH_W'(count_r), (count_r == '0) ? DATA_W'(0) : top_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire
